// File: sv/assert_macros.svh
// assertion macros used by the deframer core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/ctbd_pkg.sv
// package: types, register indexes and constants of the channel-tagged byte deframer
`default_nettype none
package ctbd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_STRING_CHANNEL    = 3'd0;
  localparam logic [2:0] REG_FLOAT_BASE        = 3'd1;
  localparam logic [2:0] REG_SHORT_BASE        = 3'd2;
  localparam logic [2:0] REG_LONG_BASE         = 3'd3;
  localparam logic [2:0] REG_CHANNELS_PER_KIND = 3'd4;
  localparam logic [2:0] REG_MAX_PAYLOAD       = 3'd5;

  // register reset values
  localparam logic [7:0] RST_STRING_CHANNEL    = 8'd0;
  localparam logic [7:0] RST_FLOAT_BASE        = 8'd16;
  localparam logic [7:0] RST_SHORT_BASE        = 8'd32;
  localparam logic [7:0] RST_LONG_BASE         = 8'd48;
  localparam logic [7:0] RST_CHANNELS_PER_KIND = 8'd10;
  localparam logic [7:0] RST_MAX_PAYLOAD       = 8'd32;

  // payload lengths of the numeric kinds
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_FLOAT = 3'd4;
  localparam logic [2:0] LEN_SHORT = 3'd2;
  localparam logic [2:0] LEN_LONG  = 3'd4;

  // string terminator
  localparam logic [7:0] TERM_BYTE = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_NUMERIC = 2'd1,
    PH_STRING  = 2'd2
  } ctbd_phase_t;

  typedef struct packed {
    logic [7:0] string_channel;
    logic [7:0] float_base;
    logic [7:0] short_base;
    logic [7:0] long_base;
    logic [7:0] channels_per_kind;
    logic [7:0] max_payload;
  } ctbd_cfg_t;

  typedef struct packed {
    logic [7:0] msg_channel;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       byte_valid;
    logic       msg_done;
    logic [7:0] msg_length;
  } ctbd_result_t;

endpackage
`default_nettype wire

// File: sv/ctbd_cfg.sv
// configuration register file of the deframer
`default_nettype none
module ctbd_cfg
  import ctbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output ctbd_cfg_t       cfg
);

  ctbd_cfg_t cfg_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.string_channel    <= RST_STRING_CHANNEL;
      cfg_r.float_base        <= RST_FLOAT_BASE;
      cfg_r.short_base        <= RST_SHORT_BASE;
      cfg_r.long_base         <= RST_LONG_BASE;
      cfg_r.channels_per_kind <= RST_CHANNELS_PER_KIND;
      cfg_r.max_payload       <= RST_MAX_PAYLOAD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRING_CHANNEL:    cfg_r.string_channel    <= cfg_wdata;
        REG_FLOAT_BASE:        cfg_r.float_base        <= cfg_wdata;
        REG_SHORT_BASE:        cfg_r.short_base        <= cfg_wdata;
        REG_LONG_BASE:         cfg_r.long_base         <= cfg_wdata;
        REG_CHANNELS_PER_KIND: cfg_r.channels_per_kind <= cfg_wdata;
        REG_MAX_PAYLOAD:       cfg_r.max_payload       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: sv/ctbd_step.sv
// framing state machine: decides what one byte does and keeps message state
`default_nettype none
module ctbd_step
  import ctbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ctbd_cfg_t  cfg,
  input  wire logic [7:0] byte_i,
  input  wire logic       step_en,
  output logic            res_valid,
  output ctbd_result_t    res
);

  ctbd_phase_t phase_r, phase_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [2:0]  exp_r, exp_nxt;

  logic        room;
  logic        term;
  logic [8:0]  sum_float, sum_short, sum_long;
  logic        hit_float, hit_short, hit_long;

  // range and capacity checks, nine bits so nothing wraps
  always_comb begin
    sum_float = {1'b0, cfg.float_base} + {1'b0, cfg.channels_per_kind};
    sum_short = {1'b0, cfg.short_base} + {1'b0, cfg.channels_per_kind};
    sum_long  = {1'b0, cfg.long_base}  + {1'b0, cfg.channels_per_kind};
    hit_float = (byte_i >= cfg.float_base) && ({1'b0, byte_i} < sum_float);
    hit_short = (byte_i >= cfg.short_base) && ({1'b0, byte_i} < sum_short);
    hit_long  = (byte_i >= cfg.long_base)  && ({1'b0, byte_i} < sum_long);
    room      = ({1'b0, count_r} + 9'd1) < {1'b0, cfg.max_payload};
    term      = (byte_i == TERM_BYTE);
  end

  // next state and result for the byte in hand
  always_comb begin
    phase_nxt      = phase_r;
    chan_nxt       = chan_r;
    count_nxt      = count_r;
    exp_nxt        = exp_r;
    res_valid      = 1'b0;
    res.data_byte  = 8'd0;
    res.byte_index = 8'd0;
    res.byte_valid = 1'b0;
    res.msg_done   = 1'b0;
    unique case (phase_r)
      PH_NUMERIC: begin
        count_nxt      = count_r + 8'd1;
        res_valid      = 1'b1;
        res.data_byte  = byte_i;
        res.byte_index = count_r;
        res.byte_valid = 1'b1;
        res.msg_done   = (count_nxt >= {5'd0, exp_r});
        if (res.msg_done) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_STRING: begin
        if (room) begin
          count_nxt      = count_r + 8'd1;
          res_valid      = 1'b1;
          res.data_byte  = byte_i;
          res.byte_index = count_r;
          res.byte_valid = 1'b1;
          res.msg_done   = term;
        end else if (term) begin
          res_valid    = 1'b1;
          res.msg_done = 1'b1;
        end
        if (term) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        // channel byte, also for the unused phase code
        chan_nxt  = byte_i;
        count_nxt = 8'd0;
        exp_nxt   = LEN_NONE;
        if (byte_i == cfg.string_channel) begin
          if (term) begin
            phase_nxt    = PH_IDLE;
            res_valid    = 1'b1;
            res.msg_done = 1'b1;
          end else begin
            phase_nxt = PH_STRING;
          end
        end else begin
          if (hit_float) begin
            exp_nxt = LEN_FLOAT;
          end else if (hit_short) begin
            exp_nxt = LEN_SHORT;
          end else if (hit_long) begin
            exp_nxt = LEN_LONG;
          end
          if (exp_nxt == LEN_NONE) begin
            phase_nxt    = PH_IDLE;
            res_valid    = 1'b1;
            res.msg_done = 1'b1;
          end else begin
            phase_nxt = PH_NUMERIC;
          end
        end
      end
    endcase
    res.msg_channel = chan_nxt;
    res.msg_length  = count_nxt;
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      chan_r  <= 8'd0;
      count_r <= 8'd0;
      exp_r   <= LEN_NONE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      chan_r  <= chan_nxt;
      count_r <= count_nxt;
      exp_r   <= exp_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/channel_tagged_byte_deframer_core.sv
// Channel-tagged byte deframer, top level.
// The in_ channel carries one received link byte per beat (in_byte_in). The first
// byte of a message names its channel; numeric channels then take 2 or 4 payload
// bytes, the string channel takes bytes up to its zero terminator.
// The out_ channel carries at most one result beat per input beat: a stored
// payload byte with its index, and/or the end of a message with its length.
// Numeric channel bytes, a nonzero string channel byte and dropped string bytes give no result beat.
// The cfg_ port writes the six framing registers; write only while no message
// is being worked on.
// An accepted byte passes the input register, then the result register, before its
// result beat is valid.
// Throughput: one byte per cycle unless a held result beat stalls it; the single framing
// state update per byte is the only loop.
// Reset (synchronous, rst_n low) empties both registers, returns the framer to
// waiting for a channel byte and loads the register defaults.
// When out_ready is low with a beat held, the result register holds; the input register still
// takes a byte whose beat makes no result, otherwise in_ready drops.
`default_nettype none
`include "assert_macros.svh"
module channel_tagged_byte_deframer_core
  import ctbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // input bytes
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_in,
  // results
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_msg_channel,
  output logic [7:0]      out_data_byte,
  output logic [7:0]      out_byte_index,
  output logic            out_byte_valid,
  output logic            out_msg_done,
  output logic [7:0]      out_msg_length
);

  ctbd_cfg_t    cfg;
  ctbd_result_t res;
  ctbd_result_t res_r;
  logic         res_valid;
  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         out_valid_r;
  logic         out_free;
  logic         s1_fire;

  ctbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ctbd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .byte_i    (s1_byte_r),
    .step_en   (s1_fire),
    .res_valid (res_valid),
    .res       (res)
  );

  // handshake between the stages
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (out_free || !res_valid);
  assign in_ready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_msg_channel = res_r.msg_channel;
  assign out_data_byte   = res_r.data_byte;
  assign out_byte_index  = res_r.byte_index;
  assign out_byte_valid  = res_r.byte_valid;
  assign out_msg_done    = res_r.msg_done;
  assign out_msg_length  = res_r.msg_length;

  // a stored byte always brings the length to its index plus one
  `ASSERT_IMPLY(a_len_follows_index, clk, rst_n, out_valid_r && out_byte_valid,
                out_msg_length == (out_byte_index + 8'd1))
  // a beat without payload carries zero data and index and ends a message
  `ASSERT_IMPLY(a_empty_beat_done, clk, rst_n, out_valid_r && !out_byte_valid,
                out_msg_done && (out_data_byte == 8'd0) && (out_byte_index == 8'd0))
  // a blocked input stage keeps its byte
  `ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !s1_fire,
               s1_valid_r && $stable(s1_byte_r))

endmodule
`default_nettype wire

// File: test/channel_tagged_byte_deframer_core_tb.sv
// self-checking testbench for the channel-tagged byte deframer core
`timescale 1ns / 100ps
module channel_tagged_byte_deframer_core_tb;
  import ctbd_pkg::*;

  localparam int DIR_ROWS    = 25;
  localparam int DIR_SPLIT   = 17;
  localparam int CFG_PHASES  = 10;
  localparam int PHASE_BYTES = 115;
  localparam int MAX_GAP     = 13;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int SHOW_MAX    = 10;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte_in;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_msg_channel;
  logic [7:0] out_data_byte;
  logic [7:0] out_byte_index;
  logic       out_byte_valid;
  logic       out_msg_done;
  logic [7:0] out_msg_length;

  channel_tagged_byte_deframer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_msg_channel(out_msg_channel),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_byte_valid (out_byte_valid),
    .out_msg_done   (out_msg_done),
    .out_msg_length (out_msg_length)
  );

  // directed stimulus: link byte, and the result typed in where it is obvious
  typedef struct {
    logic [7:0]   val;
    bit           typed;
    ctbd_result_t want;
  } dir_row_t;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    // string channel zero: the channel byte is its own terminator
    '{8'h00, 1'b1, {8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00}},
    // unknown channel
    '{8'hFF, 1'b1, {8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00}},
    // first float channel, payload extremes
    '{8'h10, 1'b0, '0},
    '{8'h00, 1'b1, {8'h10, 8'h00, 8'h00, 1'b1, 1'b0, 8'h01}},
    '{8'hFF, 1'b1, {8'h10, 8'hFF, 8'h01, 1'b1, 1'b0, 8'h02}},
    '{8'h55, 1'b0, '0},
    '{8'hAA, 1'b1, {8'h10, 8'hAA, 8'h03, 1'b1, 1'b1, 8'h04}},
    // just past the float range
    '{8'h1A, 1'b1, {8'h1A, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00}},
    // last int16 channel
    '{8'h29, 1'b0, '0},
    '{8'h12, 1'b0, '0},
    '{8'h34, 1'b0, '0},
    // last int32 channel
    '{8'h39, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'hFE, 1'b0, '0},
    // just below the float range
    '{8'h0F, 1'b1, {8'h0F, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00}},
    // string channel 0x7e, capacity 4: three stored, one dropped
    '{8'h7E, 1'b0, '0},
    '{8'h61, 1'b1, {8'h7E, 8'h61, 8'h00, 1'b1, 1'b0, 8'h01}},
    '{8'h62, 1'b0, '0},
    '{8'h63, 1'b0, '0},
    '{8'h64, 1'b0, '0},
    // terminator with no room left
    '{8'h00, 1'b1, {8'h7E, 8'h00, 8'h00, 1'b0, 1'b1, 8'h03}},
    // terminator with room: stored as a byte
    '{8'h7E, 1'b0, '0},
    '{8'h00, 1'b1, {8'h7E, 8'h00, 8'h00, 1'b1, 1'b1, 8'h01}}
  };

  // framer mirror: registers and message state
  ctbd_cfg_t   regs_shadow;
  ctbd_phase_t fr_phase;
  logic [7:0]  fr_chan;
  logic [7:0]  fr_count;
  logic [2:0]  fr_len;

  ctbd_result_t pending_results [$];
  int          mismatches;
  int          quiet_cycles;
  int          str_goal;
  int          str_sent;
  bit          tx_burst;
  bit          hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit in_span(input logic [7:0] ch, input logic [7:0] base);
    return ({1'b0, ch} >= {1'b0, base}) &&
           ({1'b0, ch} < {1'b0, base} + {1'b0, regs_shadow.channels_per_kind});
  endfunction

  function automatic ctbd_result_t pack_result(input logic [7:0] d, input logic [7:0] idx,
                                               input bit valid, input bit done);
    ctbd_result_t r;
    r.msg_channel = fr_chan;
    r.data_byte   = valid ? d : 8'h00;
    r.byte_index  = valid ? idx : 8'h00;
    r.byte_valid  = valid;
    r.msg_done    = done;
    r.msg_length  = fr_count;
    return r;
  endfunction

  // advance the framer mirror by one link byte; returns 1 when a result beat follows
  function automatic bit deframe_byte(input logic [7:0] b, output ctbd_result_t r);
    logic [7:0] idx;
    bit         done;
    bit         room;
    r = '0;
    case (fr_phase)
      PH_NUMERIC: begin
        idx      = fr_count;
        fr_count = fr_count + 8'd1;
        done     = fr_count >= {5'd0, fr_len};
        r        = pack_result(b, idx, 1'b1, done);
        if (done) fr_phase = PH_IDLE;
        return 1'b1;
      end
      PH_STRING: begin
        room = ({1'b0, fr_count} + 9'd1) < {1'b0, regs_shadow.max_payload};
        if (room) begin
          idx      = fr_count;
          fr_count = fr_count + 8'd1;
          r        = pack_result(b, idx, 1'b1, b == TERM_BYTE);
        end else if (b == TERM_BYTE) begin
          r = pack_result(TERM_BYTE, 8'h00, 1'b0, 1'b1);
        end else begin
          return 1'b0;
        end
        if (b == TERM_BYTE) fr_phase = PH_IDLE;
        return 1'b1;
      end
      default: begin
        fr_chan  = b;
        fr_count = 8'h00;
        fr_len   = LEN_NONE;
        if (b == regs_shadow.string_channel) begin
          if (b == TERM_BYTE) begin
            fr_phase = PH_IDLE;
            r        = pack_result(8'h00, 8'h00, 1'b0, 1'b1);
            return 1'b1;
          end
          fr_phase = PH_STRING;
          return 1'b0;
        end
        if (in_span(b, regs_shadow.float_base))      fr_len = LEN_FLOAT;
        else if (in_span(b, regs_shadow.short_base)) fr_len = LEN_SHORT;
        else if (in_span(b, regs_shadow.long_base))  fr_len = LEN_LONG;
        if (fr_len == LEN_NONE) begin
          fr_phase = PH_IDLE;
          r        = pack_result(8'h00, 8'h00, 1'b0, 1'b1);
          return 1'b1;
        end
        fr_phase = PH_NUMERIC;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string fmt_result(input ctbd_result_t r);
    return $sformatf("ch=%02h data=%02h idx=%02h bv=%b done=%b len=%02h",
                     r.msg_channel, r.data_byte, r.byte_index, r.byte_valid,
                     r.msg_done, r.msg_length);
  endfunction

  // mostly well-formed messages, steered by the mirror's phase
  function automatic logic [7:0] pick_byte();
    int         kind;
    int         off;
    logic [7:0] base;
    case (fr_phase)
      PH_NUMERIC: return 8'($urandom);
      PH_STRING: begin
        if (str_sent >= str_goal) return TERM_BYTE;
        str_sent++;
        return 8'($urandom_range(1, 255));
      end
      default: begin
        str_sent = 0;
        str_goal = ($urandom_range(0, 3) == 0) ?
                   $urandom_range(0, int'(regs_shadow.max_payload) + 2) : $urandom_range(0, 6);
        kind = $urandom_range(0, 9);
        if (kind < 3) return regs_shadow.string_channel;
        if (kind > 7) return 8'($urandom);
        case (kind % 3)
          0:       base = regs_shadow.float_base;
          1:       base = regs_shadow.short_base;
          default: base = regs_shadow.long_base;
        endcase
        // just outside a range
        if (kind == 7)
          return $urandom_range(0, 1) ? 8'(int'(base) + int'(regs_shadow.channels_per_kind))
                                      : 8'(int'(base) - 1);
        off = (regs_shadow.channels_per_kind == 8'd0) ? 0 :
              $urandom_range(0, int'(regs_shadow.channels_per_kind) - 1);
        return (int'(base) + off > 255) ? 8'hFF : 8'(int'(base) + off);
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_STRING_CHANNEL:    regs_shadow.string_channel    = val;
      REG_FLOAT_BASE:        regs_shadow.float_base        = val;
      REG_SHORT_BASE:        regs_shadow.short_base        = val;
      REG_LONG_BASE:         regs_shadow.long_base         = val;
      REG_CHANNELS_PER_KIND: regs_shadow.channels_per_kind = val;
      REG_MAX_PAYLOAD:       regs_shadow.max_payload       = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(input ctbd_cfg_t c);
    put_reg(REG_STRING_CHANNEL, c.string_channel);
    put_reg(REG_FLOAT_BASE, c.float_base);
    put_reg(REG_SHORT_BASE, c.short_base);
    put_reg(REG_LONG_BASE, c.long_base);
    put_reg(REG_CHANNELS_PER_KIND, c.channels_per_kind);
    put_reg(REG_MAX_PAYLOAD, c.max_payload);
    cfg_we <= 1'b0;
  endtask

  // offer one byte beat, then mirror it once accepted
  task automatic push_byte(input logic [7:0] b, input bit typed, input ctbd_result_t want);
    int           gap;
    bit           has;
    ctbd_result_t r;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    has = deframe_byte(b, r);
    if (typed) pending_results.push_back(want);
    else if (has) pending_results.push_back(r);
  endtask

  // sender waits until every expected beat is out, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    int rx_gap;
    bit rx_burst;
    rx_burst = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    ctbd_result_t got;
    ctbd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_msg_channel, out_data_byte, out_byte_index,
             out_byte_valid, out_msg_done, out_msg_length};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected result beat: %s", fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("result mismatch: expected %s, got %s", fmt_result(want), fmt_result(got));
        end
      end
    end
  end

  // watchdog on cycles without any beat or write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL channel_tagged_byte_deframer_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    ctbd_cfg_t setting;
    int        sent;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_STRING_CHANNEL;
    cfg_wdata  <= 8'h00;
    in_valid   <= 1'b0;
    in_byte_in <= 8'h00;
    quiet_cycles = 0;
    mismatches   = 0;
    tx_burst     = 1'b0;
    hold_req     = 1'b0;
    str_goal     = 0;
    str_sent     = 0;
    regs_shadow  = {RST_STRING_CHANNEL, RST_FLOAT_BASE, RST_SHORT_BASE,
                    RST_LONG_BASE, RST_CHANNELS_PER_KIND, RST_MAX_PAYLOAD};
    fr_phase     = PH_IDLE;
    fr_chan      = 8'h00;
    fr_count     = 8'h00;
    fr_len       = LEN_NONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, string rows under a small capacity
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SPLIT) begin
        drain();
        setting = regs_shadow;
        setting.string_channel = 8'h7E;
        setting.max_payload    = 8'd4;
        load_regs(setting);
      end
      push_byte(dir_tbl[i].val, dir_tbl[i].typed, dir_tbl[i].want);
    end
    drain();

    // random part over several register settings
    for (int k = 0; k < CFG_PHASES; k++) begin
      case (k)
        0: setting = {RST_STRING_CHANNEL, RST_FLOAT_BASE, RST_SHORT_BASE,
                      RST_LONG_BASE, RST_CHANNELS_PER_KIND, RST_MAX_PAYLOAD};
        1: setting = {8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'd4};
        2: setting = {8'h80, 8'hFF, 8'hFE, 8'hFD, 8'hFF, 8'hFF};
        default: begin
          setting.string_channel    = pick_reg_value();
          setting.float_base        = pick_reg_value();
          setting.short_base        = pick_reg_value();
          setting.long_base         = pick_reg_value();
          setting.channels_per_kind = ($urandom_range(0, 2) == 0) ? pick_reg_value() :
                                      8'($urandom_range(1, 24));
          case ($urandom_range(0, 3))
            0:       setting.max_payload = 8'd4;
            1:       setting.max_payload = 8'hFF;
            default: setting.max_payload = 8'($urandom_range(4, 20));
          endcase
        end
      endcase
      load_regs(setting);
      // receiver holds off while the sender keeps offering beats
      if (k == 3) begin
        hold_req = 1'b1;
        tx_burst = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_BYTES || fr_phase != PH_IDLE) begin
        if (sent >= PHASE_BYTES) str_goal = 0;
        push_byte(pick_byte(), 1'b0, '0);
        sent++;
      end
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS channel_tagged_byte_deframer_core");
    end else begin
      $display("FAIL channel_tagged_byte_deframer_core");
    end
    $finish;
  end

endmodule
